### rtl/sha1bsh_pkg.sv
// sha1bsh_pkg: sequencer states, initial chaining values and round constants
// for the SHA-1 byte stream hasher core and its checker.
// Depends on nothing.
package sha1bsh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // index 0 is H0
  localparam logic [4:0][31:0] INIT_CHAIN = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K_ROUND0 = 32'h5a827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
  localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] RND_LAST    = 7'd79;
  localparam logic [6:0] RND_PHASE1  = 7'd20;
  localparam logic [6:0] RND_PHASE2  = 7'd40;
  localparam logic [6:0] RND_PHASE3  = 7'd60;

  localparam logic [5:0] FILL_LAST   = 6'd63;  // last byte of a block
  localparam logic [5:0] FILL_PRELEN = 6'd55;  // last byte before the length field

  localparam logic [2:0] WORD_LAST   = 3'd4;

endpackage

### rtl/sha1_byte_stream_hasher_core.sv
// sha1_byte_stream_hasher_core: SHA-1 over a byte stream, one shared round unit
// under a small sequencer. Depends on sha1bsh_pkg.
//
// Channel  Direction  Handshake               Payload
// -------  ---------  ----------------------  ---------------------------------
// in       sink       in_valid_i/in_ready_o   kind_i, data_byte_i
// out      source     out_valid_o/out_ready_i digest_word_o, word_index_o, last_o
//
// Data byte: taken in idle; a block-completing byte then runs the rounds and chain add.
// Finish: pad (0x80, then zeros) to byte 55, 8 length bytes, compress; with 56 or more
// bytes held, pad to the block end, compress, then 56 zeros, 8 length bytes, compress.
// Then five words, one per cycle while out_ready_i stays high.
// in_ready_o is high only in the idle state; a stalled word holds the output state.
// Reset leaves the initial chaining values, an empty block and a zero count.
module sha1_byte_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_o
);

  sha1bsh_pkg::state_e state_q, state_d;

  // Control state
  logic [5:0]        fill_q;       // bytes held in the current block
  logic [60:0]       cnt_q;        // message bytes so far, wraps
  logic [6:0]        rnd_q;        // round counter
  logic              fin_q;        // finish sequence in progress
  logic              first_q;      // 0x80 byte still to go in
  logic              len_done_q;   // length bytes already in the block
  logic [2:0]        idx_q;        // digest word being shown
  logic [4:0][31:0]  chain_q;

  // Payload state
  logic [511:0]      blk_q;        // 16-word block, word 0 in the top bits
  logic [63:0]       len_q;        // bit length snapshot, shifted out top byte first
  logic [31:0]       a_q, b_q, c_q, d_q, e_q;

  // Sequencer outputs
  logic              in_acc, out_acc;
  logic              byte_en;
  logic [7:0]        byte_val;
  logic              start_cmp;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha1bsh_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == sha1bsh_pkg::KIND_FINISH) begin
            state_d = sha1bsh_pkg::ST_PAD;
          end else if (fill_q == sha1bsh_pkg::FILL_LAST) begin
            state_d = sha1bsh_pkg::ST_ROUND;
          end
        end
      end
      sha1bsh_pkg::ST_PAD: begin
        if (fill_q == sha1bsh_pkg::FILL_LAST) begin
          state_d = sha1bsh_pkg::ST_ROUND;
        end else if (fill_q == sha1bsh_pkg::FILL_PRELEN) begin
          state_d = sha1bsh_pkg::ST_LEN;
        end
      end
      sha1bsh_pkg::ST_LEN: begin
        if (fill_q == sha1bsh_pkg::FILL_LAST) begin
          state_d = sha1bsh_pkg::ST_ROUND;
        end
      end
      sha1bsh_pkg::ST_ROUND: begin
        if (rnd_q == sha1bsh_pkg::RND_LAST) begin
          state_d = sha1bsh_pkg::ST_ADD;
        end
      end
      sha1bsh_pkg::ST_ADD: begin
        if (!fin_q) begin
          state_d = sha1bsh_pkg::ST_IDLE;
        end else if (len_done_q) begin
          state_d = sha1bsh_pkg::ST_OUT;
        end else begin
          state_d = sha1bsh_pkg::ST_PAD;
        end
      end
      sha1bsh_pkg::ST_OUT: begin
        if (out_ready_i && idx_q == sha1bsh_pkg::WORD_LAST) begin
          state_d = sha1bsh_pkg::ST_IDLE;
        end
      end
      default: state_d = sha1bsh_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    byte_en     = 1'b0;
    byte_val    = data_byte_i;
    unique case (state_q)
      sha1bsh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        byte_en    = in_valid_i && (kind_i == sha1bsh_pkg::KIND_DATA);
      end
      sha1bsh_pkg::ST_PAD: begin
        byte_en  = 1'b1;
        byte_val = first_q ? sha1bsh_pkg::PAD_BYTE : 8'h00;
      end
      sha1bsh_pkg::ST_LEN: begin
        byte_en  = 1'b1;
        byte_val = len_q[63:56];
      end
      sha1bsh_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      sha1bsh_pkg::ST_ROUND, sha1bsh_pkg::ST_ADD: begin
      end
      default: begin
      end
    endcase
    start_cmp = (state_q != sha1bsh_pkg::ST_ROUND) && (state_d == sha1bsh_pkg::ST_ROUND);
  end

  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_o        = (idx_q == sha1bsh_pkg::WORD_LAST);

  // Shared round unit
  logic [31:0] wt, w_new, f, k, tmp;

  assign wt    = blk_q[511 -: 32];
  assign w_new = {blk_q[511-32*13 -: 32] ^ blk_q[511-32*8 -: 32] ^
                  blk_q[511-32*2 -: 32] ^ blk_q[511 -: 32]};

  always_comb begin
    if (rnd_q < sha1bsh_pkg::RND_PHASE1) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = sha1bsh_pkg::K_ROUND0;
    end else if (rnd_q < sha1bsh_pkg::RND_PHASE2) begin
      f = b_q ^ c_q ^ d_q;
      k = sha1bsh_pkg::K_ROUND1;
    end else if (rnd_q < sha1bsh_pkg::RND_PHASE3) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = sha1bsh_pkg::K_ROUND2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = sha1bsh_pkg::K_ROUND3;
    end
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha1bsh_pkg::ST_IDLE;
      fill_q     <= '0;
      cnt_q      <= '0;
      rnd_q      <= '0;
      fin_q      <= 1'b0;
      first_q    <= 1'b0;
      len_done_q <= 1'b0;
      idx_q      <= '0;
      chain_q    <= sha1bsh_pkg::INIT_CHAIN;
    end else begin
      state_q <= state_d;
      if (byte_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (in_acc && kind_i == sha1bsh_pkg::KIND_DATA) begin
        cnt_q <= cnt_q + 61'd1;
      end
      if (in_acc && kind_i == sha1bsh_pkg::KIND_FINISH) begin
        fin_q   <= 1'b1;
        first_q <= 1'b1;
      end
      if (state_q == sha1bsh_pkg::ST_PAD) begin
        first_q <= 1'b0;
      end
      if (state_q == sha1bsh_pkg::ST_LEN && fill_q == sha1bsh_pkg::FILL_LAST) begin
        len_done_q <= 1'b1;
      end
      if (start_cmp) begin
        rnd_q <= '0;
      end else if (state_q == sha1bsh_pkg::ST_ROUND) begin
        rnd_q <= rnd_q + 7'd1;
      end
      if (state_q == sha1bsh_pkg::ST_ADD) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end
      if (out_acc) begin
        if (idx_q == sha1bsh_pkg::WORD_LAST) begin
          // digest delivered: back to the empty-message state
          idx_q      <= '0;
          chain_q    <= sha1bsh_pkg::INIT_CHAIN;
          cnt_q      <= '0;
          fin_q      <= 1'b0;
          len_done_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (byte_en) begin
      blk_q <= {blk_q[503:0], byte_val};
    end else if (state_q == sha1bsh_pkg::ST_ROUND) begin
      // schedule window slides one word per round
      blk_q <= {blk_q[479:0], w_new[30:0], w_new[31]};
    end
    if (in_acc && kind_i == sha1bsh_pkg::KIND_FINISH) begin
      len_q <= {cnt_q, 3'b000};
    end else if (state_q == sha1bsh_pkg::ST_LEN) begin
      len_q <= {len_q[55:0], 8'h00};
    end
    if (start_cmp) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (state_q == sha1bsh_pkg::ST_ROUND) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= tmp;
    end
  end

endmodule

### rtl/sha1bsh_checker.sv
// sha1bsh_checker: port-level assertions for the SHA-1 byte stream hasher core,
// attached by the bind at the end. Depends on sha1bsh_pkg.
module sha1bsh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        kind_i,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_o
);

  // never taking input while a digest is shown
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest output valid");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (word_index_o == sha1bsh_pkg::WORD_LAST)))
    else $error("last flag does not match word index");

  a_word_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=>
      (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest words not consecutive");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(digest_word_o) && $stable(word_index_o)))
    else $error("stalled output transaction changed");

  // a waiting input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(kind_i) && $stable(data_byte_i)))
    else $error("stalled input transaction changed");

endmodule

bind sha1_byte_stream_hasher_core sha1bsh_checker u_sha1bsh_checker (.*);
